FILE: rtl/gcd_pkg.sv
// Shared types, constants and helper functions for the great-circle distance pipeline.
// Depends on nothing; every other rtl file takes names from here by scope.
`default_nettype none

package gcd_pkg;

	localparam int CORDIC_STAGES_DEF = 32;
	localparam int CW         = 34;
	localparam int PW         = 63;
	localparam int RW         = 62;
	localparam int DIV_STAGES = 3;
	localparam int ROOT_BITS  = 31;

	localparam logic [32:0] FULL_TURN    = 33'd3600000000;
	localparam logic [32:0] HALF_TURN    = 33'd1800000000;
	localparam logic [30:0] QUARTER_TURN = 31'd900000000;
	localparam logic [31:0] PI_Q30       = 32'd3373259426;
	localparam logic [21:0] DIV_D        = 22'd3515625;
	localparam logic [32:0] DIV_RECIP    = 33'd5124095576;
	localparam logic [CW-1:0] GAIN_Q30   = CW'(652032874);
	localparam logic [30:0] ONE_Q30      = 31'd1073741824;
	localparam logic [23:0] TWO_RADIUS   = 24'd12742000;
	localparam logic [24:0] MAX_DISTANCE = 25'd20015087;

	typedef logic signed [CW-1:0] cord_t;

	typedef struct packed {
		cord_t x;
		cord_t y;
		cord_t z;
	} cord_vec_t;

	function automatic cord_t stage_angle(input int i);
		cord_t a;
		case (i)
			0:       a = CW'(843314856);
			1:       a = CW'(497837829);
			2:       a = CW'(263043836);
			3:       a = CW'(133525158);
			4:       a = CW'(67021686);
			5:       a = CW'(33543515);
			6:       a = CW'(16775850);
			7:       a = CW'(8388437);
			8:       a = CW'(4194282);
			9:       a = CW'(2097149);
			10:      a = CW'(1048575);
			default: a = (i <= 30) ? (CW'(1) << (30 - i)) : '0;
		endcase
		return a;
	endfunction

	// fold a magnitude in degrees*1e7 into [0, 180 degrees]
	function automatic logic [30:0] fold_turn(input logic [32:0] mag);
		logic [32:0] m;
		m = (mag >= FULL_TURN) ? mag - FULL_TURN : mag;
		if (m > HALF_TURN)
			m = FULL_TURN - m;
		return m[30:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/gcd_div_cell.sv
// Division of a scaled product by a turn constant: reciprocal estimate, then correction.
// Depends on gcd_pkg for the product width, the odd divisor and its reciprocal.
`default_nettype none

module gcd_div_cell #(
	parameter int SHIFT = 10
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [gcd_pkg::PW-1:0] num,
	output logic      [30:0]            quo
);

	localparam logic [25:0] D1 = 26'(gcd_pkg::DIV_D);
	localparam logic [25:0] D2 = 26'(gcd_pkg::DIV_D) << 1;

	logic [52:0] scaled;
	logic [63:0] est_full;
	logic [52:0] back;
	logic [30:0] est_s1, est_s2, quo_s3;
	logic [25:0] low_s1, rem_s2;

	assign scaled   = 53'(num >> SHIFT);
	assign est_full = 64'(scaled[52:22]) * 64'(gcd_pkg::DIV_RECIP);
	assign back     = 53'(est_s1) * 53'(gcd_pkg::DIV_D);

	always_ff @(posedge clk) begin
		if (en) begin
			est_s1 <= est_full[62:32];
			low_s1 <= scaled[25:0];
			est_s2 <= est_s1;
			rem_s2 <= low_s1 - back[25:0];
			if (rem_s2 >= D2)
				quo_s3 <= est_s2 + 31'(2);
			else if (rem_s2 >= D1)
				quo_s3 <= est_s2 + 31'(1);
			else
				quo_s3 <= est_s2;
		end
	end

	assign quo = quo_s3;

endmodule

`default_nettype wire

FILE: rtl/gcd_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode.
// Depends on gcd_pkg for the vector type and the arctangent table.
`default_nettype none

module gcd_cordic_cell #(
	parameter int STAGE     = 0,
	parameter bit VECTORING = 1'b0
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire gcd_pkg::cord_vec_t vin,
	output gcd_pkg::cord_vec_t      vout
);

	localparam gcd_pkg::cord_t ANG = gcd_pkg::stage_angle(STAGE);

	gcd_pkg::cord_t    dx, dy;
	logic              ccw;
	gcd_pkg::cord_vec_t nxt, vec_q;

	always_comb begin
		dx  = $signed(vin.y) >>> STAGE;
		dy  = $signed(vin.x) >>> STAGE;
		ccw = VECTORING ? !($signed(vin.y) > 0) : !vin.z[gcd_pkg::CW-1];
		if (ccw) begin
			nxt.x = vin.x - dx;
			nxt.y = vin.y + dy;
			nxt.z = vin.z - ANG;
		end else begin
			nxt.x = vin.x + dx;
			nxt.y = vin.y - dy;
			nxt.z = vin.z + ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			vec_q <= nxt;
	end

	assign vout = vec_q;

endmodule

`default_nettype wire

FILE: rtl/gcd_root_cell.sv
// One integer square-root cell: settles one root bit per clock while enabled.
// Depends on gcd_pkg for the working width.
`default_nettype none

module gcd_root_cell #(
	parameter int STEP = 0
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [gcd_pkg::RW-1:0] num_in,
	input  wire logic [gcd_pkg::RW-1:0] res_in,
	output logic      [gcd_pkg::RW-1:0] num_out,
	output logic      [gcd_pkg::RW-1:0] res_out
);

	localparam logic [gcd_pkg::RW-1:0] BITV = gcd_pkg::RW'(1) << (60 - 2 * STEP);

	logic [gcd_pkg::RW-1:0] trial, num_q, res_q;

	assign trial = res_in + BITV;

	always_ff @(posedge clk) begin
		if (en) begin
			if (num_in >= trial) begin
				num_q <= num_in - trial;
				res_q <= (res_in >> 1) + BITV;
			end else begin
				num_q <= num_in;
				res_q <= res_in >> 1;
			end
		end
	end

	assign num_out = num_q;
	assign res_out = res_q;

endmodule

`default_nettype wire

FILE: rtl/great_circle_distance.sv
// Top level: haversine great-circle distance, a fully pipelined chain of cells.
// Depends on gcd_pkg, gcd_div_cell, gcd_cordic_cell and gcd_root_cell.
//
//  channel | signals                                         | direction
//  input   | in_valid, in_ready, first/second lat/lon        | into block
//  output  | out_valid, out_ready, distance_meters           | out of block
//
// One item enters per clock while the chain is not held; the path runs through
// the three-stage reciprocal dividers, two CORDIC rows, the 31-cell root row
// and 7 glue stages.
// The whole chain advances together; it holds only while the output register
// is full and not taken. Reset clears the valid bits; payload is not reset.
`default_nettype none

module great_circle_distance #(
	parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [30:0] first_latitude,
	input  wire logic signed [31:0] first_longitude,
	input  wire logic signed [30:0] second_latitude,
	input  wire logic signed [31:0] second_longitude,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [24:0] distance_meters
);

	localparam int NS  = gcd_pkg::DIV_STAGES;
	localparam int RB  = gcd_pkg::ROOT_BITS;
	localparam int LAT = 41 + 2 * CORDIC_STAGES;
	localparam int NDL = NS + CORDIC_STAGES;
	localparam int CW  = gcd_pkg::CW;
	localparam int PW  = gcd_pkg::PW;
	localparam int RW  = gcd_pkg::RW;

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// front: differences, folding, quadrant of the latitudes
	logic signed [31:0] dlat;
	logic signed [32:0] dlon;
	logic [32:0] mag_dlat, mag_dlon, mag_lat1, mag_lat2;
	logic [30:0] f_lat1, f_lat2;
	logic [30:0] m_s1 [4];
	logic [1:0]  neg_s1;

	always_comb begin
		dlat     = 32'(second_latitude) - 32'(first_latitude);
		dlon     = 33'(second_longitude) - 33'(first_longitude);
		mag_dlat = dlat[31] ? 33'(33'd0 - 33'(dlat)) : 33'(dlat);
		mag_dlon = dlon[32] ? (33'd0 - dlon) : dlon;
		mag_lat1 = first_latitude[30] ? (33'd0 - 33'(first_latitude)) : 33'(first_latitude);
		mag_lat2 = second_latitude[30] ? (33'd0 - 33'(second_latitude)) :
			33'(second_latitude);
		f_lat1   = gcd_pkg::fold_turn(mag_lat1);
		f_lat2   = gcd_pkg::fold_turn(mag_lat2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0] <= gcd_pkg::fold_turn(mag_dlat);
			m_s1[1] <= gcd_pkg::fold_turn(mag_dlon);
			neg_s1  <= {f_lat2 > gcd_pkg::QUARTER_TURN, f_lat1 > gcd_pkg::QUARTER_TURN};
			m_s1[2] <= (f_lat1 > gcd_pkg::QUARTER_TURN) ?
				31'(gcd_pkg::HALF_TURN) - f_lat1 : f_lat1;
			m_s1[3] <= (f_lat2 > gcd_pkg::QUARTER_TURN) ?
				31'(gcd_pkg::HALF_TURN) - f_lat2 : f_lat2;
		end
	end

	// scale to radians: product, then division by the turn constant
	logic [PW-1:0] p_s2 [4];
	logic [1:0]    neg_s2;
	logic [1:0]    neg_dly_q [NDL];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= PW'(m_s1[0]) * PW'(gcd_pkg::PI_Q30) + PW'(gcd_pkg::HALF_TURN);
			p_s2[1] <= PW'(m_s1[1]) * PW'(gcd_pkg::PI_Q30) + PW'(gcd_pkg::HALF_TURN);
			p_s2[2] <= PW'(m_s1[2]) * PW'(gcd_pkg::PI_Q30) + PW'(gcd_pkg::QUARTER_TURN);
			p_s2[3] <= PW'(m_s1[3]) * PW'(gcd_pkg::PI_Q30) + PW'(gcd_pkg::QUARTER_TURN);
			neg_s2  <= neg_s1;
			neg_dly_q[0] <= neg_s2;
			for (int k = 1; k < NDL; k++)
				neg_dly_q[k] <= neg_dly_q[k-1];
		end
	end

	logic [30:0]        zq  [4];
	gcd_pkg::cord_vec_t rot [4][CORDIC_STAGES+1];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		gcd_div_cell #(
			.SHIFT ((l < 2) ? 10 : 9)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (p_s2[l]),
			.quo (zq[l])
		);
		assign rot[l][0] = '{x: gcd_pkg::GAIN_Q30, y: '0, z: CW'(zq[l])};
		for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
			gcd_cordic_cell #(
				.STAGE     (s),
				.VECTORING (1'b0)
			) u_rot (
				.clk  (clk),
				.en   (en),
				.vin  (rot[l][s]),
				.vout (rot[l][s+1])
			);
		end
	end

	// haversine term
	gcd_pkg::cord_t         c1, c2;
	logic signed [2*CW-1:0] sq_lat, sq_lon, cc_full, part_full;
	logic [32:0]            hs_lat_s3, hs_lon_s3, hs_lat_s4;
	gcd_pkg::cord_t         cc_s3, part_s4;
	logic signed [CW:0]     a_sum;
	logic [30:0]            a_s5;

	always_comb begin
		c1 = neg_dly_q[NDL-1][0] ? -rot[2][CORDIC_STAGES].x : rot[2][CORDIC_STAGES].x;
		c2 = neg_dly_q[NDL-1][1] ? -rot[3][CORDIC_STAGES].x : rot[3][CORDIC_STAGES].x;
		sq_lat    = rot[0][CORDIC_STAGES].y * rot[0][CORDIC_STAGES].y;
		sq_lon    = rot[1][CORDIC_STAGES].y * rot[1][CORDIC_STAGES].y;
		cc_full   = c1 * c2;
		part_full = cc_s3 * $signed({1'b0, hs_lon_s3});
		a_sum     = $signed({2'b00, hs_lat_s4}) + $signed({part_s4[CW-1], part_s4});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hs_lat_s3 <= sq_lat[62:30];
			hs_lon_s3 <= sq_lon[62:30];
			cc_s3     <= cc_full[63:30];
			hs_lat_s4 <= hs_lat_s3;
			part_s4   <= part_full[63:30];
			if (a_sum[CW])
				a_s5 <= '0;
			else if (a_sum > $signed({4'b0000, gcd_pkg::ONE_Q30}))
				a_s5 <= gcd_pkg::ONE_Q30;
			else
				a_s5 <= a_sum[30:0];
		end
	end

	// square roots of a and 1-a
	logic [RW-1:0] rnum [2][RB+1];
	logic [RW-1:0] rres [2][RB+1];
	logic [30:0]   one_minus_a;

	assign one_minus_a = gcd_pkg::ONE_Q30 - a_s5;
	assign rnum[0][0]  = RW'({a_s5, 30'd0});
	assign rnum[1][0]  = RW'({one_minus_a, 30'd0});
	assign rres[0][0]  = '0;
	assign rres[1][0]  = '0;

	for (genvar l = 0; l < 2; l++) begin : g_root
		for (genvar k = 0; k < RB; k++) begin : g_cell
			gcd_root_cell #(
				.STEP (k)
			) u_root (
				.clk     (clk),
				.en      (en),
				.num_in  (rnum[l][k]),
				.res_in  (rres[l][k]),
				.num_out (rnum[l][k+1]),
				.res_out (rres[l][k+1])
			);
		end
	end

	// central angle by vectoring
	gcd_pkg::cord_vec_t vec [CORDIC_STAGES+1];

	assign vec[0] = '{x: CW'(rres[1][RB][30:0]), y: CW'(rres[0][RB][30:0]), z: '0};

	for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
		gcd_cordic_cell #(
			.STAGE     (s),
			.VECTORING (1'b1)
		) u_vec (
			.clk  (clk),
			.en   (en),
			.vin  (vec[s]),
			.vout (vec[s+1])
		);
	end

	// scale to metres, round, saturate
	logic [30:0] angle;
	logic [54:0] dist_s6;
	logic [55:0] rounded;
	logic [24:0] distance_s7;

	assign angle   = vec[CORDIC_STAGES].z[CW-1] ? '0 : vec[CORDIC_STAGES].z[30:0];
	assign rounded = 56'(dist_s6) + (56'(1) << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s6 <= 55'(angle) * 55'(gcd_pkg::TWO_RADIUS);
			distance_s7 <= (rounded[55:30] > 26'(gcd_pkg::MAX_DISTANCE)) ?
				gcd_pkg::MAX_DISTANCE : rounded[54:30];
		end
	end

	assign distance_meters = distance_s7;

endmodule

`default_nettype wire

FILE: rtl/gcd_checker.sv
// Port-level checks for great_circle_distance, attached by bind.
// Depends on gcd_pkg for the saturation limit.
`default_nettype none

module gcd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [24:0] distance_meters
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_meters))
		else $error("output item dropped or changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_meters <= gcd_pkg::MAX_DISTANCE)
		else $error("distance beyond half circumference");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input held off with room at the output");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the chain is frozen");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.distance_meters (distance_meters)
);

`default_nettype wire

FILE: bench/great_circle_distance_check.sv
// Checker for the great-circle distance block: watches both channels, predicts
// each distance in fixed point and compares it with the item that comes out.
// Depends on nothing but the port widths of great_circle_distance.
`timescale 1ns / 100ps

module great_circle_distance_check #(
	parameter int CORDIC_STAGES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic        [24:0] distance_meters,
	output int                 errors,
	output int                 pending
);

	localparam longint TURN = 64'd3600000000;
	localparam longint HALF = 64'd1800000000;
	localparam longint QUARTER = 64'd900000000;
	localparam longint PI_FIX = 64'd3373259426;
	localparam longint GAIN = 64'd652032874;
	localparam longint UNIT = 64'd1 << 30;
	localparam longint LIMIT_M = 64'd20015087;

	logic [24:0] expected_distances[$];

	function automatic longint arc_step(input int i);
		longint tab[11];
		tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575};
		if (i < 11)
			return tab[i];
		if (i <= 30)
			return longint'(1) << (30 - i);
		return 0;
	endfunction

	function automatic longint folded(input longint d);
		longint m;
		m = (d < 0) ? -d : d;
		m = m % TURN;
		if (m > HALF)
			m = TURN - m;
		return m;
	endfunction

	function automatic void spin(input longint ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = GAIN;
		y = 0;
		z = ang;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step(i);
			end else begin
				x += dx; y -= dy; z += arc_step(i);
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint bearing(input longint xi, input longint yi);
		longint x, y, z, dx, dy;
		x = xi;
		y = yi;
		z = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += arc_step(i);
			end else begin
				x -= dx; y += dy; z -= arc_step(i);
			end
		end
		return z;
	endfunction

	function automatic longint isqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b; r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint half_sin_sq(input longint d);
		longint unsigned m, z;
		longint c, s, p;
		m = folded(d);
		z = (m * PI_FIX + HALF) / TURN;
		spin(longint'(z), c, s);
		p = s * s;
		return longint'(longint'(unsigned'(p)) >> 30) & 64'h3_FFFF_FFFF;
	endfunction

	function automatic longint lat_cos(input longint lat);
		longint unsigned m, z;
		longint c, s;
		bit neg;
		m = folded(lat);
		neg = m > QUARTER;
		if (neg)
			m = HALF - m;
		z = (m * PI_FIX + QUARTER) / HALF;
		spin(longint'(z), c, s);
		return neg ? -c : c;
	endfunction

	function automatic logic [24:0] distance_of(input longint la1, input longint lo1,
		input longint la2, input longint lo2);
		longint cc, a, u, v, ang, d;
		cc = (lat_cos(la1) * lat_cos(la2)) >>> 30;
		a = half_sin_sq(la2 - la1) + ((cc * half_sin_sq(lo2 - lo1)) >>> 30);
		if (a < 0) a = 0;
		if (a > UNIT) a = UNIT;
		u = isqrt(longint'(a) << 30);
		v = isqrt(longint'(UNIT - a) << 30);
		ang = bearing(v, u);
		if (ang < 0) ang = 0;
		d = (ang * 64'd12742000 + (64'd1 << 29)) >> 30;
		if (d > LIMIT_M) d = LIMIT_M;
		return d[24:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_distances.size() == 0) begin
					if (errors < 10)
						$display("unexpected item: distance %0d", distance_meters);
					errors <= errors + 1;
				end else begin
					if (expected_distances[0] !== distance_meters) begin
						if (errors < 10)
							$display("distance mismatch: expected %0d, got %0d",
								expected_distances[0], distance_meters);
						errors <= errors + 1;
					end
					void'(expected_distances.pop_front());
				end
			end
			if (in_valid && in_ready)
				expected_distances.insert(expected_distances.size(),
					distance_of(first_latitude, first_longitude,
					second_latitude, second_longitude));
			pending <= expected_distances.size();
		end
	end

endmodule

FILE: bench/great_circle_distance_test.sv
// Testbench top for great_circle_distance: drives position pairs under varied
// idling and hold-off, and gives the verdict from great_circle_distance_check.
// Depends on great_circle_distance and great_circle_distance_check.
`timescale 1ns / 100ps

module great_circle_distance_test;

	localparam int LATENCY = 41 + 2 * 32;
	localparam longint CYCLE_LIMIT = 1000000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [30:0] first_latitude = '0;
	logic signed [31:0] first_longitude = '0;
	logic signed [30:0] second_latitude = '0;
	logic signed [31:0] second_longitude = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic        [24:0] distance_meters;
	int                 errors;
	int                 pending;
	int                 send_idle = 0;
	int                 take_stall = 0;
	bit                 hold_off = 1'b0;
	longint             cycles = 0;

	always #6 clk = ~clk;

	great_circle_distance i_dut (.*);

	great_circle_distance_check i_check (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n)
			out_ready <= !hold_off && ($urandom_range(99) >= take_stall);

	function automatic int pick_lat(input int mode);
		case (mode)
			0: return int'($urandom_range(1800000000)) - 900000000;
			1: return int'($urandom);
			default: return int'($urandom_range(2000)) - 1000;
		endcase
	endfunction

	function automatic int pick_lon(input int mode);
		case (mode)
			0: return int'(longint'($urandom_range(32'd3600000000)) - longint'(1800000000));
			1: return int'($urandom);
			default: return int'($urandom_range(2000)) - 1000;
		endcase
	endfunction

	task automatic offer(input int la1, input int lo1, input int la2, input int lo2);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		first_latitude <= 31'(la1);
		first_longitude <= lo1;
		second_latitude <= 31'(la2);
		second_longitude <= lo2;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic random_items(input int count);
		int m;
		int la;
		int lo;
		for (int k = 0; k < count; k++) begin
			m = $urandom_range(9);
			la = pick_lat(m < 7 ? 0 : 1);
			lo = pick_lon(m < 7 ? 0 : 1);
			if (m == 9)
				offer(la, lo, la + pick_lat(2), lo + pick_lon(2));
			else
				offer(la, lo, pick_lat(m < 7 ? 0 : 1), pick_lon(m < 7 ? 0 : 1));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int lim;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		offer(0, 0, 0, 0);
		offer(900000000, 0, -900000000, 0);
		offer(-900000000, 1800000000, 900000000, -1800000000);
		offer(0, 1800000000, 0, -1800000000);
		offer(0, 0, 0, 1800000000);
		offer(0, -1800000000, 0, 1800000000);
		offer(0, 0, 0, 1);
		offer(1, 0, 0, 0);
		offer(1073741823, 2147483647, -1073741824, 32'h8000_0000);
		offer(-1073741824, 32'h8000_0000, 1073741823, 2147483647);
		offer(1000000000, 0, -1000000000, 0);
		offer(1700000000, 100, -1700000000, 32'h8000_0000);
		offer(-1, -1, -715827883, 32'hAAAA_AAAA);
		offer(715827882, 32'h5555_5555, 0, 0);
		offer(515000000, -1270000, 407000000, -740000000);
		offer(0, 0, 0, 1799999999);
		offer(899999999, 0, 899999999, 1800000000);
		drain();
		random_items(250);
		send_idle = 88;
		random_items(150);
		drain();
		send_idle = 0;
		take_stall = 88;
		random_items(200);
		drain();
		send_idle = 34;
		take_stall = 34;
		random_items(200);
		send_idle = 0;
		take_stall = 0;
		hold_off = 1'b1;
		fork
			random_items(200);
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();
		random_items(100);
		in_valid <= 1'b0;
		lim = 0;
		while (pending != 0 && lim < 100000) begin
			@(posedge clk);
			lim++;
		end
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
